// ===== sv/two_axis_focus_calibrator_defines.svh =====
// Assertion macros shared by the focus calibrator modules.
`ifndef TWO_AXIS_FOCUS_CALIBRATOR_DEFINES_SVH
`define TWO_AXIS_FOCUS_CALIBRATOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define TAFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tafc: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TAFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tafc: same-cycle check failed");

`endif

// ===== sv/tafc_pkg.sv =====
package tafc_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned SAMPLE_BITS     = 12;
  localparam int unsigned OFFSET_BITS     = 24;
  localparam int unsigned MAX_OFFSET_BITS = OFFSET_BITS - 1;
  localparam int unsigned FLAG_BITS       = 10;
  localparam int unsigned KIND_BITS       = 3;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned CFG_DATA_BITS   = 23;

  // Sample error below this value counts as in focus.
  localparam int unsigned LOCK_ERR = 30;

  // Command codes.
  localparam logic [KIND_BITS-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_START   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_CANCEL  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_RESTART = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_RESET   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIDDLE_A   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIDDLE_B   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_OFFSET = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_A_EN  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_B_EN  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_BITS-1:0]     MIDDLE_RESET     = 12'd2048;
  localparam logic [MAX_OFFSET_BITS-1:0] MAX_OFFSET_RESET = 23'd10000;

  // Bit positions in the flag word.
  localparam int unsigned F_START    = 0;
  localparam int unsigned F_MSTART_A = 1;
  localparam int unsigned F_MSTART_B = 2;
  localparam int unsigned F_FIN_A    = 3;
  localparam int unsigned F_FIN_B    = 4;
  localparam int unsigned F_IN_A     = 5;
  localparam int unsigned F_IN_B     = 6;
  localparam int unsigned F_NO_LIGHT = 7;
  localparam int unsigned F_LOCK_A   = 8;
  localparam int unsigned F_LOCK_B   = 9;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   dark_switch;
    logic                   motor_a_idle;
    logic                   motor_a_moving;
    logic                   motor_b_idle;
    logic                   motor_b_moving;
    logic                   motor_a_fault;
    logic                   motor_b_fault;
  } tafc_in_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0]          flags;
    logic                          locked;
    logic signed [OFFSET_BITS-1:0] stored_offset_a;
    logic signed [OFFSET_BITS-1:0] stored_offset_b;
    logic signed [OFFSET_BITS-1:0] applied_offset_a;
    logic signed [OFFSET_BITS-1:0] applied_offset_b;
  } tafc_out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]     middle_a;
    logic [SAMPLE_BITS-1:0]     middle_b;
    logic [MAX_OFFSET_BITS-1:0] max_offset;
    logic                       axis_a_enabled;
    logic                       axis_b_enabled;
  } tafc_cfg_t;

  // Per-axis slice of the flag word.
  typedef struct packed {
    logic mstart;
    logic fin;
    logic in_run;
    logic locked;
  } tafc_axis_flags_t;

endpackage

// ===== sv/tafc_cfg.sv =====
module tafc_cfg
  import tafc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output tafc_cfg_t                cfg
);

  tafc_cfg_t cfg_r;
  tafc_cfg_t cfg_nxt;

  // Decode the register index; writes beyond the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIDDLE_A:   cfg_nxt.middle_a       = cfg_data[SAMPLE_BITS-1:0];
        CFG_MIDDLE_B:   cfg_nxt.middle_b       = cfg_data[SAMPLE_BITS-1:0];
        CFG_MAX_OFFSET: cfg_nxt.max_offset     = cfg_data[MAX_OFFSET_BITS-1:0];
        CFG_AXIS_A_EN:  cfg_nxt.axis_a_enabled = cfg_data[0];
        CFG_AXIS_B_EN:  cfg_nxt.axis_b_enabled = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.middle_a       <= MIDDLE_RESET;
      cfg_r.middle_b       <= MIDDLE_RESET;
      cfg_r.max_offset     <= MAX_OFFSET_RESET;
      cfg_r.axis_a_enabled <= 1'b1;
      cfg_r.axis_b_enabled <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tafc_axis.sv =====
module tafc_axis
  import tafc_pkg::*;
(
  input  logic                          active,
  input  tafc_axis_flags_t              flg_i,
  input  logic                          motor_idle,
  input  logic                          motor_moving,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [SAMPLE_BITS-1:0]        middle,
  input  logic [MAX_OFFSET_BITS-1:0]    lim,
  input  logic signed [OFFSET_BITS-1:0] integ_i,
  output tafc_axis_flags_t              flg_o,
  output logic signed [OFFSET_BITS-1:0] integ_o
);

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned SUM_W  = OFFSET_BITS + 2;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] diff_abs;
  logic                     err_small;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_s;
  logic signed [SUM_W-1:0]  clamped;

  // Sample minus middle, and its magnitude for the focus test.
  assign diff      = $signed({1'b0, sample}) - $signed({1'b0, middle});
  assign diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign err_small = diff_abs < DIFF_W'(LOCK_ERR);

  // Integrate the error and clamp to the symmetric limit.
  assign sum   = {{2{integ_i[OFFSET_BITS-1]}}, integ_i}
               + {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
  assign lim_s = $signed({{(SUM_W-MAX_OFFSET_BITS){1'b0}}, lim});

  always_comb begin
    if (sum > lim_s) begin
      clamped = lim_s;
    end else if (sum < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = sum;
    end
  end

  // Wait for the motor to start, then integrate once when it stops.
  always_comb begin
    flg_o   = flg_i;
    integ_o = integ_i;
    if (active) begin
      if ((!motor_idle || flg_i.in_run) && !flg_i.fin) begin
        flg_o.in_run = 1'b1;
        if (motor_moving) begin
          flg_o.mstart = 1'b1;
        end else if (flg_i.mstart) begin
          integ_o   = clamped[OFFSET_BITS-1:0];
          flg_o.fin = 1'b1;
        end
      end else begin
        flg_o.fin = 1'b1;
      end
      if (flg_o.fin && err_small) begin
        flg_o.locked = 1'b1;
      end
    end
  end

endmodule

// ===== sv/tafc_core.sv =====
`include "two_axis_focus_calibrator_defines.svh"

module tafc_core
  import tafc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tafc_cfg_t cfg,
  input  logic      item_fire,
  input  tafc_in_t  item,
  output tafc_out_t result
);

  logic [FLAG_BITS-1:0]          flags_r, flags_nxt;
  logic signed [OFFSET_BITS-1:0] integ_a_r, integ_a_nxt;
  logic signed [OFFSET_BITS-1:0] integ_b_r, integ_b_nxt;
  logic signed [OFFSET_BITS-1:0] use_a_r, use_a_nxt;
  logic signed [OFFSET_BITS-1:0] use_b_r, use_b_nxt;

  logic [FLAG_BITS-1:0]          f_pre;
  logic                          ok_a, ok_b, gate;
  tafc_axis_flags_t              axa_i, axa_o, axb_i, axb_o;
  logic signed [OFFSET_BITS-1:0] axa_integ, axb_integ;

  // Overall lock decision from the flag word and axis health.
  function automatic logic lock_decide(input logic [FLAG_BITS-1:0] f,
                                       input logic h_a, input logic h_b);
    logic r;
    r = f[F_NO_LIGHT]
      || (!h_a && h_b && f[F_LOCK_B])
      || (h_a && !h_b && f[F_LOCK_A])
      || (f[F_LOCK_A] && f[F_LOCK_B]);
    return r;
  endfunction

  assign ok_a = !item.motor_a_fault && cfg.axis_a_enabled;
  assign ok_b = !item.motor_b_fault && cfg.axis_b_enabled;

  // Darkness handling comes first on a tick and cancels the run.
  always_comb begin
    f_pre = flags_r;
    if (item.dark_switch) begin
      f_pre[F_NO_LIGHT] = 1'b1;
      f_pre[F_START]    = 1'b0;
      f_pre[F_MSTART_A] = 1'b0;
      f_pre[F_FIN_A]    = 1'b0;
      f_pre[F_IN_A]     = 1'b0;
      f_pre[F_MSTART_B] = 1'b0;
      f_pre[F_FIN_B]    = 1'b0;
      f_pre[F_IN_B]     = 1'b0;
    end else begin
      f_pre[F_NO_LIGHT] = 1'b0;
    end
  end

  assign gate = f_pre[F_START] && !lock_decide(f_pre, ok_a, ok_b);

  assign axa_i = '{mstart: f_pre[F_MSTART_A], fin: f_pre[F_FIN_A],
                   in_run: f_pre[F_IN_A], locked: f_pre[F_LOCK_A]};
  assign axb_i = '{mstart: f_pre[F_MSTART_B], fin: f_pre[F_FIN_B],
                   in_run: f_pre[F_IN_B], locked: f_pre[F_LOCK_B]};

  tafc_axis u_axis_a (
    .active       (gate),
    .flg_i        (axa_i),
    .motor_idle   (item.motor_a_idle),
    .motor_moving (item.motor_a_moving),
    .sample       (item.sample_a),
    .middle       (cfg.middle_a),
    .lim          (cfg.max_offset),
    .integ_i      (integ_a_r),
    .flg_o        (axa_o),
    .integ_o      (axa_integ)
  );

  tafc_axis u_axis_b (
    .active       (gate),
    .flg_i        (axb_i),
    .motor_idle   (item.motor_b_idle),
    .motor_moving (item.motor_b_moving),
    .sample       (item.sample_b),
    .middle       (cfg.middle_b),
    .lim          (cfg.max_offset),
    .integ_i      (integ_b_r),
    .flg_o        (axb_o),
    .integ_o      (axb_integ)
  );

  // Next state for each command.
  always_comb begin
    flags_nxt   = flags_r;
    integ_a_nxt = integ_a_r;
    integ_b_nxt = integ_b_r;
    use_a_nxt   = use_a_r;
    use_b_nxt   = use_b_r;
    case (item.kind)
      KIND_TICK: begin
        flags_nxt             = f_pre;
        flags_nxt[F_MSTART_A] = axa_o.mstart;
        flags_nxt[F_FIN_A]    = axa_o.fin;
        flags_nxt[F_IN_A]     = axa_o.in_run;
        flags_nxt[F_LOCK_A]   = axa_o.locked;
        flags_nxt[F_MSTART_B] = axb_o.mstart;
        flags_nxt[F_FIN_B]    = axb_o.fin;
        flags_nxt[F_IN_B]     = axb_o.in_run;
        flags_nxt[F_LOCK_B]   = axb_o.locked;
        integ_a_nxt           = axa_integ;
        integ_b_nxt           = axb_integ;
      end
      KIND_START: begin
        if (flags_r[F_FIN_A]) begin
          flags_nxt[F_MSTART_A] = 1'b0;
          flags_nxt[F_FIN_A]    = 1'b0;
          flags_nxt[F_IN_A]     = 1'b0;
        end
        if (flags_r[F_FIN_B]) begin
          flags_nxt[F_MSTART_B] = 1'b0;
          flags_nxt[F_FIN_B]    = 1'b0;
          flags_nxt[F_IN_B]     = 1'b0;
        end
        flags_nxt[F_START] = 1'b1;
        use_a_nxt          = integ_a_r;
        use_b_nxt          = integ_b_r;
      end
      KIND_CANCEL: begin
        flags_nxt[F_START]    = 1'b0;
        flags_nxt[F_MSTART_A] = 1'b0;
        flags_nxt[F_FIN_A]    = 1'b0;
        flags_nxt[F_IN_A]     = 1'b0;
        flags_nxt[F_MSTART_B] = 1'b0;
        flags_nxt[F_FIN_B]    = 1'b0;
        flags_nxt[F_IN_B]     = 1'b0;
      end
      KIND_RESTART: begin
        flags_nxt          = '0;
        flags_nxt[F_START] = 1'b1;
      end
      KIND_RESET: begin
        flags_nxt   = '0;
        integ_a_nxt = '0;
        integ_b_nxt = '0;
        use_a_nxt   = '0;
        use_b_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // Calibration state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      integ_a_r <= '0;
      integ_b_r <= '0;
      use_a_r   <= '0;
      use_b_r   <= '0;
    end else if (item_fire) begin
      flags_r   <= flags_nxt;
      integ_a_r <= integ_a_nxt;
      integ_b_r <= integ_b_nxt;
      use_a_r   <= use_a_nxt;
      use_b_r   <= use_b_nxt;
    end
  end

  // Result reflects the state after this item.
  assign result.flags            = flags_nxt;
  assign result.locked           = lock_decide(flags_nxt, ok_a, ok_b);
  assign result.stored_offset_a  = integ_a_nxt;
  assign result.stored_offset_b  = integ_b_nxt;
  assign result.applied_offset_a = use_a_nxt;
  assign result.applied_offset_b = use_b_nxt;

  // A reset command clears all calibration state.
  `TAFC_ASSERT_NEXT(a_reset_clears, clk, rst_n, item_fire && item.kind == KIND_RESET, flags_r == '0 && integ_a_r == '0 && use_b_r == '0)
  // A restart leaves only the start flag.
  `TAFC_ASSERT_NEXT(a_restart_start_only, clk, rst_n, item_fire && item.kind == KIND_RESTART, flags_r == FLAG_BITS'(1) << F_START)
  // Start loads the applied offsets from the integrators.
  `TAFC_ASSERT_NEXT(a_start_applies, clk, rst_n, item_fire && item.kind == KIND_START, use_a_r == $past(integ_a_r) && use_b_r == $past(integ_b_r))

endmodule

// ===== sv/two_axis_focus_calibrator.sv =====
// Two-axis focus calibration sequencer. Each item is a command (tick, start,
// cancel, restart or reset) and produces exactly one result item carrying the
// flag word, the lock decision and the stored and applied offsets after that
// command. Throughput is one item per clock while the output is not stalled:
// items are accepted into an input register and results are offered from a
// result register, with all per-item work (flag update plus one add-and-clamp
// per axis) between them. A stalled output holds the result register and,
// once the input register is also full, the input. Configuration writes take
// effect at the next clock edge.
`include "two_axis_focus_calibrator_defines.svh"

module two_axis_focus_calibrator
  import tafc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tafc_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tafc_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  tafc_cfg_t cfg;
  tafc_in_t  s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r;
  tafc_out_t out_data_r;
  tafc_out_t result;
  logic      advance, in_fire, core_fire;

  // The result register can take a new item when empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_fire   = in_valid && !in_stall;
  assign core_fire = s1_valid_r && advance;

  tafc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tafc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_fire (core_fire),
    .item      (s1_item_r),
    .result    (result)
  );

  // Input register.
  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input side stalls only while an item waits in the input register.
  `TAFC_ASSERT_NOW(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  // An item that moves forward always shows up as a result.
  `TAFC_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, core_fire, out_valid_r)

endmodule
